// ===== design/bnms_pkg.sv =====
package bnms_pkg;

   localparam int MAX_BOXES_DEF = 64;
   localparam logic [15:0] THRESH_RESET = 16'd45875;

   typedef struct packed {
      logic [15:0] left_x;
      logic [15:0] top_y;
      logic [15:0] right_x;
      logic [15:0] bottom_y;
      logic [15:0] score;
      logic [7:0]  class_tag;
      logic        final_box;
   } req_type;

   typedef struct packed {
      logic [15:0] kept_left_x;
      logic [15:0] kept_top_y;
      logic [15:0] kept_right_x;
      logic [15:0] kept_bottom_y;
      logic [15:0] kept_score;
      logic [7:0]  kept_class;
      logic        end_of_list;
      logic        overflowed;
   } rsp_type;

   typedef struct packed {
      logic [15:0] left_x;
      logic [15:0] top_y;
      logic [15:0] right_x;
      logic [15:0] bottom_y;
      logic [15:0] score;
      logic [7:0]  class_tag;
   } box_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic    ins;
      logic    pop;
      box_type item;
   } cell_ctl_type;

   // overlap unit status and result word
   typedef struct packed {
      logic    active;
      logic    valid;
      logic    keep;
      box_type item;
   } iou_res_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PICK,
      ST_SWEEP
   } state_type;

   function automatic box_type req_to_box(req_type r);
      box_type b;
      b.left_x    = r.left_x;
      b.top_y     = r.top_y;
      b.right_x   = r.right_x;
      b.bottom_y  = r.bottom_y;
      b.score     = r.score;
      b.class_tag = r.class_tag;
      return b;
   endfunction

endpackage

// ===== design/bnms_cell.sv =====
module bnms_cell import bnms_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         push_sel,
   input  box_type      prev_item,
   input  logic         prev_valid,
   input  logic         prev_shift,
   input  box_type      next_item,
   input  logic         next_valid,
   output box_type      item,
   output logic         valid,
   output logic         shift
);

   box_type item_ff, item_in;
   logic    valid_ff, valid_in;

   // move toward the tail when the slot is empty or the new box scores higher
   assign shift = ctl.ins && (!valid_ff || (item_ff.score < ctl.item.score));

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff;
      if (ctl.ins) begin
         if (shift) begin
            // a shifting slot takes the box of its shifting neighbor, else the new box
            item_in  = prev_shift ? prev_item : ctl.item;
            valid_in = prev_shift ? prev_valid : 1'b1;
         end
      end else begin
         if (ctl.pop) begin
            item_in  = next_item;
            valid_in = next_valid;
         end
         if (push_sel) begin
            item_in  = ctl.item;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item  = item_ff;
   assign valid = valid_ff;

endmodule

// ===== design/bnms_iou.sv =====
module bnms_iou import bnms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] thresh,
   input  box_type     kept,
   input  logic        in_valid,
   input  box_type     in_item,
   output iou_res_type res
);

   logic [15:0] x1, y1, x2, y2;
   logic [15:0] w_in, h_in;
   logic signed [16:0] bw_in, bh_in, kw, kh;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   box_type item1_ff, item2_ff, item3_ff, item4_ff;
   logic [15:0] w1_ff, h1_ff;
   logic signed [16:0] bw1_ff, bh1_ff;
   logic signed [33:0] karea_ff;
   logic [31:0] inter2_ff;
   logic signed [33:0] areab2_ff;
   logic [31:0] inter3_ff;
   logic signed [35:0] uni3_in;
   logic [33:0] uni3_ff;
   logic pos3_ff, pos4_ff;
   logic [49:0] prod4_ff;
   logic [47:0] lhs4_ff;

   always_comb begin
      x1 = (kept.left_x > in_item.left_x) ? kept.left_x : in_item.left_x;
      y1 = (kept.top_y > in_item.top_y) ? kept.top_y : in_item.top_y;
      x2 = (kept.right_x < in_item.right_x) ? kept.right_x : in_item.right_x;
      y2 = (kept.bottom_y < in_item.bottom_y) ? kept.bottom_y : in_item.bottom_y;
      w_in  = (x2 > x1) ? (x2 - x1) : 16'd0;
      h_in  = (y2 > y1) ? (y2 - y1) : 16'd0;
      bw_in = $signed({1'b0, in_item.right_x}) - $signed({1'b0, in_item.left_x});
      bh_in = $signed({1'b0, in_item.bottom_y}) - $signed({1'b0, in_item.top_y});
      kw    = $signed({1'b0, kept.right_x}) - $signed({1'b0, kept.left_x});
      kh    = $signed({1'b0, kept.bottom_y}) - $signed({1'b0, kept.top_y});
      uni3_in = $signed({{2{karea_ff[33]}}, karea_ff})
              + $signed({{2{areab2_ff[33]}}, areab2_ff})
              - $signed({4'b0000, inter2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      item1_ff <= in_item;
      w1_ff    <= w_in;
      h1_ff    <= h_in;
      bw1_ff   <= bw_in;
      bh1_ff   <= bh_in;
      karea_ff <= kw * kh;

      item2_ff  <= item1_ff;
      inter2_ff <= w1_ff * h1_ff;
      areab2_ff <= bw1_ff * bh1_ff;

      item3_ff  <= item2_ff;
      inter3_ff <= inter2_ff;
      uni3_ff   <= uni3_in[33:0];
      pos3_ff   <= (uni3_in > 36'sd0);

      item4_ff <= item3_ff;
      prod4_ff <= thresh * uni3_ff;
      lhs4_ff  <= {inter3_ff, 16'h0000};
      pos4_ff  <= pos3_ff;
   end

   always_comb begin
      res.active = v1_ff | v2_ff | v3_ff | v4_ff;
      res.valid  = v4_ff;
      res.keep   = !(pos4_ff && ({2'b00, lhs4_ff} > prod4_ff));
      res.item   = item4_ff;
   end

endmodule

// ===== design/box_nms_greedy.sv =====
// Channel  | Ports                               | Handshake
// request  | start, busy, req_item (req_type)    | word taken when start & !busy
// result   | rsp_strobe, rsp_item (rsp_type)     | single-cycle strobe per word, no back-pressure
// csr      | csr_valid, csr_ready, csr_data      | threshold written when valid & ready
//
// In load the sorted chain inserts each box as it is taken, ready for the next.
// After the closing box, each kept box is followed by a sweep in which the
// lower-ranked boxes still alive rotate once through the 4-stage overlap unit.
// Reset empties the chain and loads the 0.7 threshold; no clearing pass.
// busy holds from the closing box until the last kept word is presented.
module box_nms_greedy import bnms_pkg::*; #(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_strobe,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(MAX_BOXES + 1);

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, left_ff, left_in, wr_idx;
   logic        ovf_ff, ovf_in;
   logic [15:0] thr_ff;
   box_type     kept_ff, kept_in;
   logic        has_kept_ff, has_kept_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_item_ff, rsp_item_in;

   logic        ins, pop, issue, push, emit, emit_eol;
   cell_ctl_type ctl;
   iou_res_type res;

   box_type cell_item  [MAX_BOXES];
   logic    cell_valid [MAX_BOXES];
   logic    cell_shift [MAX_BOXES];
   logic    push_sel   [MAX_BOXES];

   // a survivor of the sweep goes back to the tail of the chain
   assign push   = res.valid && res.keep;
   assign wr_idx = cnt_ff - CW'(pop);

   assign ctl.ins  = ins;
   assign ctl.pop  = pop;
   assign ctl.item = ins ? req_to_box(req_item) : res.item;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_BOXES; gi++) begin : g_cell
         assign push_sel[gi] = push && (wr_idx == CW'(gi));
         if (gi == 0) begin : g_head
            bnms_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .push_sel   (push_sel[gi]),
               .prev_item  (ctl.item),
               .prev_valid (1'b1),
               .prev_shift (1'b0),
               .next_item  (cell_item[gi+1]),
               .next_valid (cell_valid[gi+1]),
               .item       (cell_item[gi]),
               .valid      (cell_valid[gi]),
               .shift      (cell_shift[gi])
            );
         end else if (gi == MAX_BOXES - 1) begin : g_tail
            bnms_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .push_sel   (push_sel[gi]),
               .prev_item  (cell_item[gi-1]),
               .prev_valid (cell_valid[gi-1]),
               .prev_shift (cell_shift[gi-1]),
               .next_item  (cell_item[gi]),
               .next_valid (1'b0),
               .item       (cell_item[gi]),
               .valid      (cell_valid[gi]),
               .shift      (cell_shift[gi])
            );
         end else begin : g_mid
            bnms_cell u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctl        (ctl),
               .push_sel   (push_sel[gi]),
               .prev_item  (cell_item[gi-1]),
               .prev_valid (cell_valid[gi-1]),
               .prev_shift (cell_shift[gi-1]),
               .next_item  (cell_item[gi+1]),
               .next_valid (cell_valid[gi+1]),
               .item       (cell_item[gi]),
               .valid      (cell_valid[gi]),
               .shift      (cell_shift[gi])
            );
         end
      end
   endgenerate

   bnms_iou u_iou (
      .clock    (clock),
      .reset    (reset),
      .thresh   (thr_ff),
      .kept     (kept_ff),
      .in_valid (issue),
      .in_item  (cell_item[0]),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         cnt_ff        <= '0;
         left_ff       <= '0;
         ovf_ff        <= 1'b0;
         thr_ff        <= THRESH_RESET;
         has_kept_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         left_ff       <= left_in;
         ovf_ff        <= ovf_in;
         has_kept_ff   <= has_kept_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kept_ff     <= kept_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in    = state_ff;
      left_in     = left_ff;
      ovf_in      = ovf_ff;
      kept_in     = kept_ff;
      has_kept_in = has_kept_ff;
      ins         = 1'b0;
      pop         = 1'b0;
      issue       = 1'b0;
      emit        = 1'b0;
      emit_eol    = 1'b0;
      busy        = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               // drop the box when the chain is full, but flag the overflow
               if (cnt_ff < CW'(MAX_BOXES)) begin
                  ins = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item.final_box) begin
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            if (cnt_ff == '0) begin
               // chain empty: the held box is the last kept one
               emit        = has_kept_ff;
               emit_eol    = 1'b1;
               has_kept_in = 1'b0;
               ovf_in      = 1'b0;
               state_in    = ST_LOAD;
            end else begin
               // head survived every earlier sweep: keep it
               emit        = has_kept_ff;
               kept_in     = cell_item[0];
               has_kept_in = 1'b1;
               pop         = 1'b1;
               left_in     = cnt_ff - CW'(1);
               state_in    = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (left_ff != '0) begin
               // rotate the next box through the overlap unit
               pop     = 1'b1;
               issue   = 1'b1;
               left_in = left_ff - CW'(1);
            end else if (!res.active) begin
               state_in = ST_PICK;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      cnt_in = cnt_ff + CW'(ins) + CW'(push) - CW'(pop);

      rsp_strobe_in             = emit;
      rsp_item_in.kept_left_x   = kept_ff.left_x;
      rsp_item_in.kept_top_y    = kept_ff.top_y;
      rsp_item_in.kept_right_x  = kept_ff.right_x;
      rsp_item_in.kept_bottom_y = kept_ff.bottom_y;
      rsp_item_in.kept_score    = kept_ff.score;
      rsp_item_in.kept_class    = kept_ff.class_tag;
      rsp_item_in.end_of_list   = emit_eol;
      rsp_item_in.overflowed    = ovf_ff;
   end

   assign csr_ready  = (state_ff == ST_LOAD);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ===== design/bnms_check.sv =====
module bnms_check import bnms_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // a set ends with the block idle again
   a_eol_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.end_of_list |-> !busy)
      else $error("last word of a set while still busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.end_of_list |-> busy)
      else $error("inner word of a set while idle");

   a_eol_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.end_of_list |=> !rsp_strobe)
      else $error("word after the end of a set");

   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.final_box |=> busy)
      else $error("closing box did not start the sweep");

   a_open_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_item.final_box |=> !busy)
      else $error("inner box left the load phase");

endmodule

bind box_nms_greedy bnms_check u_bnms_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

// ===== sim/tb_box_nms_greedy.sv =====
module tb_box_nms_greedy;
   import bnms_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int RANDOM_BOXES   = 36;

   // Greedy NMS scoreboard: mirrors the box store, ranks and sweeps on the
   // closing box and holds the kept words that the block must emit.
   class nms_scoreboard;
      logic [15:0] thresh;
      box_type     boxes[64];
      int          n_boxes;
      bit          dropped;
      rsp_type     kept_q[$];
      int          errors;

      function new();
         thresh  = THRESH_RESET;
         n_boxes = 0;
         dropped = 0;
         errors  = 0;
      endfunction

      function longint area(box_type b);
         return (longint'(b.right_x) - longint'(b.left_x)) *
                (longint'(b.bottom_y) - longint'(b.top_y));
      endfunction

      function bit too_close(box_type a, box_type b);
         longint x1, y1, x2, y2, w, h, inter, uni;
         x1 = (a.left_x > b.left_x) ? a.left_x : b.left_x;
         y1 = (a.top_y > b.top_y) ? a.top_y : b.top_y;
         x2 = (a.right_x < b.right_x) ? a.right_x : b.right_x;
         y2 = (a.bottom_y < b.bottom_y) ? a.bottom_y : b.bottom_y;
         w = (x2 - x1 > 0) ? x2 - x1 : 0;
         h = (y2 - y1 > 0) ? y2 - y1 : 0;
         inter = w * h;
         uni = area(a) + area(b) - inter;
         if (uni <= 0) return 0;
         return (inter * 65536) > (longint'(thresh) * uni);
      endfunction

      // note an accepted box; on the closing box rank, sweep and queue
      function void note(req_type r);
         int  rank[64];
         bit  gone[64];
         int  kept[$];
         int  i, j;
         rsp_type w;
         if (n_boxes < 64) begin
            boxes[n_boxes] = req_to_box_tb(r);
            n_boxes++;
         end else begin
            dropped = 1;
         end
         if (!r.final_box) return;
         // stable insertion by falling score
         for (i = 0; i < n_boxes; i++) begin
            j = i;
            while (j > 0 && boxes[rank[j-1]].score < boxes[i].score) begin
               rank[j] = rank[j-1];
               j--;
            end
            rank[j] = i;
         end
         for (i = 0; i < 64; i++) gone[i] = 0;
         for (i = 0; i < n_boxes; i++) begin
            if (gone[i]) continue;
            kept = {kept, rank[i]};
            for (j = i + 1; j < n_boxes; j++)
               if (!gone[j] && too_close(boxes[rank[i]], boxes[rank[j]])) gone[j] = 1;
         end
         for (i = 0; i < kept.size(); i++) begin
            w.kept_left_x   = boxes[kept[i]].left_x;
            w.kept_top_y    = boxes[kept[i]].top_y;
            w.kept_right_x  = boxes[kept[i]].right_x;
            w.kept_bottom_y = boxes[kept[i]].bottom_y;
            w.kept_score    = boxes[kept[i]].score;
            w.kept_class    = boxes[kept[i]].class_tag;
            w.end_of_list   = (i == kept.size() - 1);
            w.overflowed    = dropped;
            kept_q = {kept_q, w};
         end
         n_boxes = 0;
         dropped = 0;
      endfunction

      function box_type req_to_box_tb(req_type r);
         box_type b;
         b = {r.left_x, r.top_y, r.right_x, r.bottom_y, r.score, r.class_tag};
         return b;
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (kept_q.size() == 0) begin
            $display("%0t: unexpected kept word, expected none, actual %h", $realtime, a);
            errors++;
            return;
         end
         e = kept_q.pop_front();
         if (e.kept_left_x   !== a.kept_left_x   || e.kept_top_y  !== a.kept_top_y  ||
             e.kept_right_x  !== a.kept_right_x  || e.kept_bottom_y !== a.kept_bottom_y ||
             e.kept_score    !== a.kept_score    || e.kept_class  !== a.kept_class  ||
             e.end_of_list   !== a.end_of_list   || e.overflowed  !== a.overflowed) begin
            $display("%0t: kept word mismatch expected %h actual %h", $realtime, e, a);
            if (e.kept_left_x !== a.kept_left_x)
               $display("  left_x   expected %h actual %h", e.kept_left_x, a.kept_left_x);
            if (e.kept_top_y !== a.kept_top_y)
               $display("  top_y    expected %h actual %h", e.kept_top_y, a.kept_top_y);
            if (e.kept_right_x !== a.kept_right_x)
               $display("  right_x  expected %h actual %h", e.kept_right_x, a.kept_right_x);
            if (e.kept_bottom_y !== a.kept_bottom_y)
               $display("  bottom_y expected %h actual %h", e.kept_bottom_y, a.kept_bottom_y);
            if (e.kept_score !== a.kept_score)
               $display("  score    expected %h actual %h", e.kept_score, a.kept_score);
            if (e.kept_class !== a.kept_class)
               $display("  class    expected %h actual %h", e.kept_class, a.kept_class);
            if (e.end_of_list !== a.end_of_list)
               $display("  last     expected %b actual %b", e.end_of_list, a.end_of_list);
            if (e.overflowed !== a.overflowed)
               $display("  overflow expected %b actual %b", e.overflowed, a.overflowed);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   nms_scoreboard sb;
   int          idle_cycles;
   int          burst_left;
   box_type     cluster_base;

   box_nms_greedy uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Monitor: sample every handshake on the rising edge, before the block
   // updates its own outputs.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note(req_item);
         end
         if (rsp_strobe) begin
            sb.check(rsp_item);
         end
         if (csr_valid && csr_ready) begin
            sb.thresh = csr_data;
         end
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Present one box word at the falling edge and hold it until taken.
   // Returns at the falling edge after acceptance with start still high,
   // so a back-to-back word never drops start.
   task automatic send_box(input req_type r);
      req_item <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start and idle the sender for the requested gap.
   task automatic sender_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Burst/gap shaping of the sender.
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 6));
      end
   endtask

   // Hold off until every kept word is out and the block has settled.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (sb.kept_q.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_thresh(input logic [15:0] v);
      drain();
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type mk(input logic [15:0] l, t, r, b, s,
                                  input logic [7:0] c, input logic f);
      req_type q;
      q = {l, t, r, b, s, c, f};
      return q;
   endfunction

   // Random box: mostly jittered copies of a cluster base so pairs overlap,
   // with full-range noise, inverted boxes and extreme corners mixed in.
   function automatic req_type rand_box(input logic f);
      req_type q;
      int      mode;
      int      jit;
      mode = $urandom_range(0, 9);
      jit  = $urandom_range(0, 3) == 0 ? 255 : 15;
      q.left_x   = 16'(cluster_base.left_x   + $urandom_range(0, jit));
      q.top_y    = 16'(cluster_base.top_y    + $urandom_range(0, jit));
      q.right_x  = 16'(cluster_base.right_x  + $urandom_range(0, jit));
      q.bottom_y = 16'(cluster_base.bottom_y + $urandom_range(0, jit));
      if (mode == 7) begin
         q.left_x = 16'($urandom); q.top_y = 16'($urandom);
         q.right_x = 16'($urandom); q.bottom_y = 16'($urandom);
      end else if (mode == 8) begin
         q.right_x = 16'(q.left_x - $urandom_range(1, 200));
      end else if (mode == 9) begin
         q.left_x   = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
         q.top_y    = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
         q.right_x  = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
         q.bottom_y = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      end
      // ties are frequent so arrival order matters
      q.score     = $urandom_range(0, 2) == 0 ? 16'($urandom_range(0, 3) * 16'h5555)
                                              : 16'($urandom);
      q.class_tag = 8'($urandom);
      q.final_box = f;
      return q;
   endfunction

   function automatic box_type rand_base();
      box_type b;
      b.left_x   = 16'($urandom_range(0, 60000));
      b.top_y    = 16'($urandom_range(0, 60000));
      b.right_x  = 16'(b.left_x + $urandom_range(16, 4000));
      b.bottom_y = 16'(b.top_y + $urandom_range(16, 4000));
      b.score    = '0;
      b.class_tag = '0;
      return b;
   endfunction

   // One set of n boxes with occasional cluster switches.
   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) cluster_base = rand_base();
         send_box(rand_box(i == n - 1));
         pace();
      end
   endtask

   initial begin
      int sent;
      int n;
      sb          = new();
      idle_cycles = 0;
      burst_left  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      cluster_base = rand_base();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets at the reset threshold.
      send_box(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1));
      send_box(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
      // identical boxes, equal score: the earlier one survives
      send_box(mk(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h8000, 8'h01, 1'b0));
      send_box(mk(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h8000, 8'h02, 1'b1));
      // inverted box next to a normal one covering it
      send_box(mk(16'h0300, 16'h0100, 16'h0100, 16'h0300, 16'hF000, 8'h03, 1'b0));
      send_box(mk(16'h0100, 16'h0100, 16'h0300, 16'h0300, 16'h1000, 8'h04, 1'b1));
      // disjoint boxes, scores out of order and tied
      send_box(mk(16'h0000, 16'h0000, 16'h0010, 16'h0010, 16'h0005, 8'h05, 1'b0));
      send_box(mk(16'h1000, 16'h1000, 16'h1010, 16'h1010, 16'hFFFF, 8'h06, 1'b0));
      send_box(mk(16'h2000, 16'h2000, 16'h2010, 16'h2010, 16'h0005, 8'h07, 1'b1));

      // Threshold zero: any positive overlap suppresses.
      write_thresh(16'h0000);
      send_box(mk(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h4000, 8'h10, 1'b0));
      send_box(mk(16'h00FF, 16'h00FF, 16'h0200, 16'h0200, 16'h4001, 8'h11, 1'b1));

      // Threshold maximum: identical boxes still suppress.
      write_thresh(16'hFFFF);
      send_box(mk(16'h0400, 16'h0400, 16'h0500, 16'h0500, 16'h2000, 8'h20, 1'b0));
      send_box(mk(16'h0400, 16'h0400, 16'h0500, 16'h0500, 16'h3000, 8'h21, 1'b0));
      send_box(mk(16'h0400, 16'h0400, 16'h0480, 16'h0500, 16'h1000, 8'h22, 1'b1));

      // Random sets across several thresholds.
      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_thresh(THRESH_RESET);
            1: write_thresh(16'h8000);
            2: write_thresh(16'h0000);
            3: write_thresh(16'hFFFF);
            default: write_thresh(16'($urandom));
         endcase
         while (sent < (phase + 1) * RANDOM_BOXES / 6) begin
            n = $urandom_range(1, 8);
            send_set(n);
            sent += n;
         end
      end

      // Capacity: a full then overflowing set, and one with a dropped closer.
      write_thresh(THRESH_RESET);
      send_set(66);
      for (int i = 0; i < 64; i++) send_box(rand_box(1'b0));
      send_box(rand_box(1'b0));
      send_box(rand_box(1'b1));
      send_set(3);

      drain();
      if (sb.errors == 0 && sb.kept_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (sb.kept_q.size() != 0)
            $display("%0t: %0d kept words never arrived", $realtime, sb.kept_q.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/bnms_pkg.sv
design/bnms_cell.sv
design/bnms_iou.sv
design/box_nms_greedy.sv
design/bnms_check.sv
sim/tb_box_nms_greedy.sv
